### rtl/core/pcts_pkg.sv
`timescale 1ns / 1ps

package pcts_pkg;

   // Sizes
   localparam int SLOTS_DEFAULT = 1024;
   localparam int QUEUE_DEPTH   = 2;

   // Statistic modes
   localparam logic [2:0] MODE_INSTANT = 3'd0;
   localparam logic [2:0] MODE_SUM     = 3'd1;
   localparam logic [2:0] MODE_AVERAGE = 3'd2;
   localparam logic [2:0] MODE_MINIMUM = 3'd3;
   localparam logic [2:0] MODE_MAXIMUM = 3'd4;
   localparam logic [2:0] MODE_STD     = 3'd5;

   // Operations
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [9:0]         slot;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [9:0]         slot_out;
      logic signed [31:0] statistic;
      logic [15:0]        samples_taken;
      logic               overflowed;
   } rsp_type;

   // Classified item held in the queue
   typedef struct packed {
      logic               operation;
      logic               in_range;
      logic [9:0]         slot;
      logic signed [31:0] sample;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_link_type;

   typedef struct packed {
      logic signed [47:0] primary;
      logic [63:0]        square;
      logic [15:0]        count;
      logic               overflow;
   } slot_entry_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_FETCH,
      B_UPDATE,
      B_DIV_P,
      B_DIV_S,
      B_MEANSQ,
      B_VAR,
      B_SQRT,
      B_REPORT
   } back_state_type;

endpackage

### rtl/core/pcts_front.sv
`timescale 1ns / 1ps

module pcts_front #(
   parameter int SLOTS = pcts_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  pcts_pkg::req_type          req_item,
   input  logic                       clearing,
   input  logic                       pop,
   output logic                       busy,
   output pcts_pkg::queue_link_type   head
);

   pcts_pkg::job_type q_ff [pcts_pkg::QUEUE_DEPTH];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push;
   pcts_pkg::job_type job;

   // Classify the incoming item
   always_comb begin
      job.operation = req_item.operation;
      job.slot      = req_item.slot;
      job.sample    = req_item.sample;
      job.in_range  = (32'(req_item.slot) < 32'(SLOTS));
   end

   assign busy = (cnt_ff == 2'(pcts_pkg::QUEUE_DEPTH)) || clearing;
   assign push = start && !busy;

   assign head.valid = (cnt_ff != 2'd0);
   assign head.job   = q_ff[rp_ff];

   // Store transfers into the queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= job;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### rtl/core/pcts_divider.sv
`timescale 1ns / 1ps

module pcts_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] acc_ff;
   logic [15:0] rem_ff;
   logic [15:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [16:0] rem_sh;
   logic [16:0] diff;
   logic        ge;

   // One restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff, acc_ff[63]};
      diff   = rem_sh - {1'b0, div_ff};
      ge     = (rem_sh >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         acc_ff <= {acc_ff[62:0], ge};
         rem_ff <= ge ? diff[15:0] : rem_sh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 6'd63);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = acc_ff;

endmodule

### rtl/core/pcts_sqrt.sv
`timescale 1ns / 1ps

module pcts_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, res_ff, bit_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff, done_ff;
   logic [63:0] trial;
   logic        take;

   // One result bit per cycle
   always_comb begin
      trial = res_ff + bit_ff;
      take  = (v_ff >= trial);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (run_ff) begin
         if (take) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 5'd31);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

### rtl/core/pcts_back.sv
`timescale 1ns / 1ps

module pcts_back #(
   parameter int SLOTS = pcts_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                mode,
   input  pcts_pkg::queue_link_type  head,
   output logic                      pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   output pcts_pkg::rsp_type         rsp_item
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   pcts_pkg::slot_entry_type mem [SLOTS];

   pcts_pkg::back_state_type state_ff, state_in;
   pcts_pkg::job_type        job_ff, job_in;
   pcts_pkg::slot_entry_type rd_ff;
   pcts_pkg::rsp_type        rsp_item_ff, rsp_item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [63:0]              sq_ff, sq_in;
   logic [47:0]              qp_ff, qp_in;
   logic [63:0]              msq_ff, msq_in;
   logic [63:0]              m2_ff, m2_in;
   logic [31:0]              root_ff, root_in;

   logic                     mem_we, mem_re;
   logic [AW-1:0]            mem_wa, mem_ra;
   pcts_pkg::slot_entry_type mem_wd, upd;

   logic                     div_start, div_done;
   logic [63:0]              div_dividend, div_q;
   logic [15:0]              div_divisor;
   logic                     sqrt_start, sqrt_done;
   logic [31:0]              sqrt_root;

   logic signed [31:0]       s;
   logic signed [47:0]       p, s48;
   logic signed [48:0]       sum49, mean49, val49;
   logic [31:0]              mag;
   logic [47:0]              pmag;
   logic [64:0]              sqacc;
   logic [15:0]              n16;
   logic [63:0]              variance;
   logic [32:0]              sat;

   function automatic logic [32:0] sat32(input logic signed [48:0] v);
      if (v > 49'sd2147483647) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < -49'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b0, v[31:0]};
      end
   endfunction

   pcts_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   pcts_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (variance),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   // Datapath terms
   always_comb begin
      s     = job_ff.sample;
      p     = rd_ff.primary;
      s48   = 48'(s);
      sum49 = 49'(p) + 49'(s);
      mag   = s[31] ? 32'(-s) : 32'(s);
      pmag  = p[47] ? 48'(-p) : 48'(p);
      sqacc = {1'b0, rd_ff.square} + {1'b0, sq_ff};
      n16   = (rd_ff.count == 16'd0) ? 16'd1 : rd_ff.count;
      mean49 = p[47] ? -$signed({1'b0, qp_ff}) : $signed({1'b0, qp_ff});
      variance = ((qp_ff[47:32] == 16'd0) && (msq_ff > m2_ff)) ? (msq_ff - m2_ff) : 64'd0;
   end

   // Fold the sample into the entry
   always_comb begin
      upd       = rd_ff;
      upd.count = (rd_ff.count == 16'hFFFF) ? rd_ff.count : rd_ff.count + 16'd1;
      if (rd_ff.count == 16'hFFFF) begin
         upd.overflow = 1'b1;
      end
      case (mode)
         pcts_pkg::MODE_INSTANT: begin
            upd.primary = s48;
         end
         pcts_pkg::MODE_SUM, pcts_pkg::MODE_AVERAGE, pcts_pkg::MODE_STD: begin
            if (sum49[48] != sum49[47]) begin
               upd.primary  = sum49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               upd.overflow = 1'b1;
            end else begin
               upd.primary = sum49[47:0];
            end
            if (mode == pcts_pkg::MODE_STD) begin
               if (sqacc[64]) begin
                  upd.square   = '1;
                  upd.overflow = 1'b1;
               end else begin
                  upd.square = sqacc[63:0];
               end
            end
         end
         pcts_pkg::MODE_MINIMUM: begin
            if ((rd_ff.count == 16'd0) || (s48 < p)) begin
               upd.primary = s48;
            end
         end
         pcts_pkg::MODE_MAXIMUM: begin
            if ((rd_ff.count == 16'd0) || (s48 > p)) begin
               upd.primary = s48;
            end
         end
         default: begin
         end
      endcase
   end

   // Pick and clamp the reported statistic
   always_comb begin
      case (mode)
         pcts_pkg::MODE_AVERAGE: val49 = mean49;
         pcts_pkg::MODE_STD:     val49 = $signed({17'd0, root_ff});
         default:                val49 = 49'(p);
      endcase
      sat = sat32(val49);
   end

   // Next state and controls
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      clr_in       = clr_ff;
      sq_in        = sq_ff;
      qp_in        = qp_ff;
      msq_in       = msq_ff;
      m2_in        = m2_ff;
      root_in      = root_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = 1'b0;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = AW'(job_ff.slot);
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = AW'(head.job.slot);
      div_start    = 1'b0;
      div_dividend = {16'd0, pmag};
      div_divisor  = n16;
      sqrt_start   = 1'b0;
      case (state_ff)
         pcts_pkg::B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = pcts_pkg::B_IDLE;
            end
         end
         pcts_pkg::B_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               job_in   = head.job;
               mem_re   = 1'b1;
               state_in = pcts_pkg::B_FETCH;
            end
         end
         pcts_pkg::B_FETCH: begin
            sq_in = mag * mag;
            if (job_ff.operation == pcts_pkg::OP_ACCUMULATE) begin
               state_in = job_ff.in_range ? pcts_pkg::B_UPDATE : pcts_pkg::B_IDLE;
            end else if (job_ff.in_range &&
                         ((mode == pcts_pkg::MODE_AVERAGE) || (mode == pcts_pkg::MODE_STD))) begin
               div_start = 1'b1;
               state_in  = pcts_pkg::B_DIV_P;
            end else begin
               state_in = pcts_pkg::B_REPORT;
            end
         end
         pcts_pkg::B_UPDATE: begin
            mem_we   = 1'b1;
            mem_wd   = upd;
            state_in = pcts_pkg::B_IDLE;
         end
         pcts_pkg::B_DIV_P: begin
            if (div_done) begin
               qp_in = div_q[47:0];
               if (mode == pcts_pkg::MODE_STD) begin
                  div_start    = 1'b1;
                  div_dividend = rd_ff.square;
                  state_in     = pcts_pkg::B_DIV_S;
               end else begin
                  state_in = pcts_pkg::B_REPORT;
               end
            end
         end
         pcts_pkg::B_DIV_S: begin
            if (div_done) begin
               msq_in   = div_q;
               state_in = pcts_pkg::B_MEANSQ;
            end
         end
         pcts_pkg::B_MEANSQ: begin
            m2_in    = qp_ff[31:0] * qp_ff[31:0];
            state_in = pcts_pkg::B_VAR;
         end
         pcts_pkg::B_VAR: begin
            sqrt_start = 1'b1;
            state_in   = pcts_pkg::B_SQRT;
         end
         pcts_pkg::B_SQRT: begin
            if (sqrt_done) begin
               root_in  = sqrt_root;
               state_in = pcts_pkg::B_REPORT;
            end
         end
         pcts_pkg::B_REPORT: begin
            rsp_valid_in         = 1'b1;
            rsp_item_in.slot_out = job_ff.slot;
            if (job_ff.in_range) begin
               rsp_item_in.statistic     = sat[31:0];
               rsp_item_in.samples_taken = rd_ff.count;
               rsp_item_in.overflowed    = rd_ff.overflow | sat[32];
               mem_we                    = 1'b1;
            end else begin
               rsp_item_in.statistic     = '0;
               rsp_item_in.samples_taken = '0;
               rsp_item_in.overflowed    = 1'b0;
            end
            state_in = pcts_pkg::B_IDLE;
         end
         default: begin
            state_in = pcts_pkg::B_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcts_pkg::B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sq_ff       <= sq_in;
      qp_ff       <= qp_in;
      msq_ff      <= msq_in;
      m2_ff       <= m2_in;
      root_ff     <= root_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign clearing  = (state_ff == pcts_pkg::B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### rtl/core/per_column_time_statistics.sv
`timescale 1ns / 1ps

// Channel    Ports                                  Direction  Handshake
// request    start, busy, req_item                  in         start & !busy
// result     rsp_valid, rsp_item                    out        one-cycle strobe
// config     psel, penable, pwrite, paddr, pwdata,  in/out     APB write, pready high
//            prdata, pready
//
// In the back end an accumulate goes through memory read, square and update.
// A read in average mode adds one 64-step divide, and in std mode it adds two
// divides, a square and a 32-step square root.
// A two-entry queue lets start be taken while the back end works.
// After reset the slot memory is cleared with busy high.
// Results cannot be stalled.

module per_column_time_statistics #(
   parameter int SLOTS = pcts_pkg::SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pcts_pkg::req_type   req_item,
   output logic                rsp_valid,
   output pcts_pkg::rsp_type   rsp_item,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [2:0]               mode_ff;
   logic                     clearing;
   logic                     pop;
   pcts_pkg::queue_link_type head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {29'd0, mode_ff} : 32'd0;

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pcts_pkg::MODE_INSTANT;
      end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         mode_ff <= pwdata[2:0];
      end
   end

   pcts_front #(.SLOTS(SLOTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .clearing (clearing),
      .pop      (pop),
      .busy     (busy),
      .head     (head)
   );

   pcts_back #(.SLOTS(SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in adjacent cycles");

   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("not busy during memory clear");

   a_empty_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.samples_taken == 16'd0)) |->
      ((rsp_item.statistic == 32'sd0) && !rsp_item.overflowed))
      else $error("empty slot reported nonzero statistic");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

endmodule
